@@ src/pgg_pkg.sv @@
// Shared types, register codes and region tables for the ghost point generator.
package pgg_pkg;

  localparam int unsigned BUFF_W     = 23;
  localparam int unsigned SCALE_W    = 25;
  localparam int unsigned CAP_W      = 21;
  localparam int unsigned SCALE_FRAC = 24;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REGIONS_3D = 26;
  localparam int unsigned REGIONS_2D = 8;

  typedef enum logic [1:0] {
    REG_BUFF  = 2'd0,
    REG_SCALE = 2'd1,
    REG_DIM   = 2'd2,
    REG_CAP   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [BUFF_W-1:0]  buff;
    logic [SCALE_W-1:0] scale;
    logic               is3;
    logic [CAP_W-1:0]   cap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    buff:  23'd1677722,
    scale: 25'd13981013,
    is3:   1'b1,
    cap:   21'd1048576
  };

  // Per-axis shift codes; index 0 is x, 1 is y, 2 is z.
  localparam logic [1:0] SH_Z = 2'b00;
  localparam logic [1:0] SH_P = 2'b01;
  localparam logic [1:0] SH_N = 2'b10;

  typedef logic [2:0][1:0] shift_t;

  function automatic shift_t mk(logic [1:0] sx, logic [1:0] sy, logic [1:0] sz);
    shift_t s;
    s[0] = sx;
    s[1] = sy;
    s[2] = sz;
    return s;
  endfunction

  // Region order: faces, then edges, then corners.
  function automatic shift_t region3d(logic [4:0] r);
    shift_t s;
    unique case (r)
      5'd0:    s = mk(SH_Z, SH_Z, SH_P);
      5'd1:    s = mk(SH_P, SH_Z, SH_Z);
      5'd2:    s = mk(SH_Z, SH_N, SH_Z);
      5'd3:    s = mk(SH_N, SH_Z, SH_Z);
      5'd4:    s = mk(SH_Z, SH_P, SH_Z);
      5'd5:    s = mk(SH_Z, SH_Z, SH_N);
      5'd6:    s = mk(SH_Z, SH_P, SH_P);
      5'd7:    s = mk(SH_P, SH_Z, SH_P);
      5'd8:    s = mk(SH_Z, SH_N, SH_P);
      5'd9:    s = mk(SH_N, SH_Z, SH_P);
      5'd10:   s = mk(SH_P, SH_P, SH_Z);
      5'd11:   s = mk(SH_P, SH_N, SH_Z);
      5'd12:   s = mk(SH_N, SH_N, SH_Z);
      5'd13:   s = mk(SH_N, SH_P, SH_Z);
      5'd14:   s = mk(SH_P, SH_Z, SH_N);
      5'd15:   s = mk(SH_Z, SH_N, SH_N);
      5'd16:   s = mk(SH_N, SH_Z, SH_N);
      5'd17:   s = mk(SH_Z, SH_P, SH_N);
      5'd18:   s = mk(SH_P, SH_P, SH_P);
      5'd19:   s = mk(SH_P, SH_N, SH_P);
      5'd20:   s = mk(SH_N, SH_N, SH_P);
      5'd21:   s = mk(SH_N, SH_P, SH_P);
      5'd22:   s = mk(SH_P, SH_P, SH_N);
      5'd23:   s = mk(SH_P, SH_N, SH_N);
      5'd24:   s = mk(SH_N, SH_N, SH_N);
      5'd25:   s = mk(SH_N, SH_P, SH_N);
      default: s = mk(SH_Z, SH_Z, SH_Z);
    endcase
    return s;
  endfunction

  function automatic shift_t region2d(logic [2:0] r);
    shift_t s;
    unique case (r)
      3'd0:    s = mk(SH_P, SH_Z, SH_Z);
      3'd1:    s = mk(SH_Z, SH_N, SH_Z);
      3'd2:    s = mk(SH_N, SH_Z, SH_Z);
      3'd3:    s = mk(SH_Z, SH_P, SH_Z);
      3'd4:    s = mk(SH_P, SH_P, SH_Z);
      3'd5:    s = mk(SH_P, SH_N, SH_Z);
      3'd6:    s = mk(SH_N, SH_N, SH_Z);
      3'd7:    s = mk(SH_N, SH_P, SH_Z);
      default: s = mk(SH_Z, SH_Z, SH_Z);
    endcase
    return s;
  endfunction

  function automatic logic axis_hit(logic [1:0] s, logic lo, logic hi, logic pos);
    logic h;
    unique case (s)
      SH_P:    h = lo;
      SH_N:    h = hi;
      SH_Z:    h = pos;
      default: h = 1'b0;
    endcase
    return h;
  endfunction

endpackage

@@ src/pgg_cfg.sv @@
// APB register file holding band width, scale, dimension and ghost capacity.
module pgg_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pgg_pkg::ADDR_W-1:0]   paddr,
  input  logic [pgg_pkg::DATA_W-1:0]   pwdata,
  output logic [pgg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output pgg_pkg::cfg_t                cfg_o
);

  pgg_pkg::cfg_t     cfg_q;
  pgg_pkg::reg_idx_e sel;
  logic              wr_en;

  assign sel    = pgg_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pgg_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (sel)
        pgg_pkg::REG_BUFF:  cfg_q.buff  <= pwdata[pgg_pkg::BUFF_W-1:0];
        pgg_pkg::REG_SCALE: cfg_q.scale <= pwdata[pgg_pkg::SCALE_W-1:0];
        pgg_pkg::REG_DIM:   cfg_q.is3   <= pwdata[0];
        pgg_pkg::REG_CAP:   cfg_q.cap   <= pwdata[pgg_pkg::CAP_W-1:0];
        default:            cfg_q       <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      pgg_pkg::REG_BUFF:  prdata = pgg_pkg::DATA_W'(cfg_q.buff);
      pgg_pkg::REG_SCALE: prdata = pgg_pkg::DATA_W'(cfg_q.scale);
      pgg_pkg::REG_DIM:   prdata = pgg_pkg::DATA_W'(cfg_q.is3);
      pgg_pkg::REG_CAP:   prdata = pgg_pkg::DATA_W'(cfg_q.cap);
      default:            prdata = '0;
    endcase
  end

endmodule

@@ src/pgg_sched.sv @@
// Region test, ghost numbering and per-result beat sequencer.
module pgg_sched #(
  parameter int unsigned CW = 24,
  parameter int unsigned IB = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pgg_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [IB-1:0]          point_index_i,
  input  logic [CW-1:0]          x_coord_i,
  input  logic [CW-1:0]          y_coord_i,
  input  logic [CW-1:0]          z_coord_i,
  input  logic                   last_point_i,
  output logic                   beat_valid_o,
  input  logic                   beat_ready_i,
  output logic                   beat_ghost_o,
  output logic [IB-1:0]          beat_index_o,
  output logic [IB-1:0]          beat_ord_o,
  output logic                   beat_ovf_o,
  output logic                   beat_last_o,
  output logic [2:0]             beat_neg_o,
  output logic [2:0][CW:0]       beat_mag_o
);

  localparam int unsigned CMPW = ((pgg_pkg::BUFF_W > CW) ? pgg_pkg::BUFF_W : CW) + 2;
  localparam int unsigned CAPW = ((pgg_pkg::CAP_W > IB + 1) ? pgg_pkg::CAP_W : IB + 1) + 1;
  localparam int unsigned DW   = CW + 3;
  localparam int unsigned MW   = CW + 1;
  localparam int unsigned NR   = pgg_pkg::REGIONS_3D;

  localparam logic [CMPW-1:0] ONE_C   = CMPW'(1) << CW;
  localparam logic [CMPW-1:0] HALF_C  = CMPW'(1) << (CW - 1);
  localparam logic [CAPW-1:0] LIMIT_C = CAPW'(1) << IB;
  localparam logic signed [DW-1:0] ONE_D  = DW'(1) << CW;
  localparam logic signed [DW-1:0] HALF_D = DW'(1) << (CW - 1);

  // Accept-side region test
  logic [2:0][CW-1:0] c_in;
  logic [CMPW-1:0]    buff_eff;
  logic [2:0]         lo, hi, pos, act;
  logic [NR-1:0]      mask_in;
  logic               all_pos;
  logic [1:0]         n_act;
  logic [2:0]         hits_n;
  logic [CAPW-1:0]    cap_eff, cnt_ext, avail;
  logic [2:0]         take;
  logic               ovf_in;

  // Point registers
  logic               pt_v_q, pt_v_d;
  logic               first_q, first_d;
  logic [NR-1:0]      mask_q, mask_d;
  logic [2:0]         left_q, left_d;
  logic [IB:0]        count_q, count_d;
  logic [IB-1:0]      ord_q, idx_q;
  logic [2:0][CW-1:0] crd_q;
  logic               ovf_q;

  // Beat generation
  logic [4:0]                 sel;
  pgg_pkg::shift_t            shift_sel;
  logic                       last_c;
  logic [2:0]                 neg_c;
  logic [2:0][MW-1:0]         mag_c;
  logic signed [2:0][DW-1:0]  d_c;
  logic                       beat_v_q, beat_v_d;
  logic                       beat_take, beat_fire, in_fire;

  assign c_in[0] = x_coord_i;
  assign c_in[1] = y_coord_i;
  assign c_in[2] = z_coord_i;

  assign buff_eff = (CMPW'(cfg_i.buff) > HALF_C) ? HALF_C : CMPW'(cfg_i.buff);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = |c_in[a];
      lo[a]  = pos[a] && (CMPW'(c_in[a]) < buff_eff);
      hi[a]  = (CMPW'(c_in[a]) + buff_eff) > ONE_C;
      act[a] = lo[a] || hi[a];
    end
  end

  always_comb begin
    pgg_pkg::shift_t s3;
    pgg_pkg::shift_t s2;
    logic            h3, h2;
    for (int r = 0; r < NR; r++) begin
      s3 = pgg_pkg::region3d(5'(r));
      s2 = pgg_pkg::region2d(3'(r));
      h3 = pgg_pkg::axis_hit(s3[0], lo[0], hi[0], pos[0])
        && pgg_pkg::axis_hit(s3[1], lo[1], hi[1], pos[1])
        && pgg_pkg::axis_hit(s3[2], lo[2], hi[2], pos[2]);
      h2 = (r < pgg_pkg::REGIONS_2D)
        && pgg_pkg::axis_hit(s2[0], lo[0], hi[0], pos[0])
        && pgg_pkg::axis_hit(s2[1], lo[1], hi[1], pos[1]);
      mask_in[r] = cfg_i.is3 ? h3 : h2;
    end
  end

  // Hit count is 2^k - 1 over the axes that sit in a band; zero if any used coordinate is zero.
  assign all_pos = pos[0] && pos[1] && (!cfg_i.is3 || pos[2]);
  assign n_act   = 2'(act[0]) + 2'(act[1]) + 2'(cfg_i.is3 && act[2]);
  assign hits_n  = all_pos ? 3'((4'd1 << n_act) - 4'd1) : 3'd0;

  assign cap_eff = (CAPW'(cfg_i.cap) > LIMIT_C) ? LIMIT_C : CAPW'(cfg_i.cap);
  assign cnt_ext = CAPW'(count_q);
  assign avail   = (cnt_ext < cap_eff) ? (cap_eff - cnt_ext) : '0;
  assign ovf_in  = avail < CAPW'(hits_n);
  assign take    = ovf_in ? avail[2:0] : hits_n;

  // Lowest pending region goes next.
  always_comb begin
    sel = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = 5'(i);
      end
    end
  end

  always_comb begin
    if (first_q) begin
      shift_sel = pgg_pkg::mk(pgg_pkg::SH_Z, pgg_pkg::SH_Z, pgg_pkg::SH_Z);
    end else if (cfg_i.is3) begin
      shift_sel = pgg_pkg::region3d(sel);
    end else begin
      shift_sel = pgg_pkg::region2d(sel[2:0]);
    end
  end

  assign last_c = first_q ? (left_q == 3'd0) : (left_q == 3'd1);

  always_comb begin
    logic signed [DW-1:0] off;
    for (int a = 0; a < 3; a++) begin
      unique case (shift_sel[a])
        pgg_pkg::SH_P: off = ONE_D;
        pgg_pkg::SH_N: off = -ONE_D;
        default:       off = '0;
      endcase
      d_c[a]   = $signed({3'b000, crd_q[a]}) - HALF_D + off;
      neg_c[a] = d_c[a][DW-1];
      mag_c[a] = neg_c[a] ? MW'(-d_c[a]) : MW'(d_c[a]);
    end
  end

  assign beat_take  = !beat_v_q || beat_ready_i;
  assign beat_fire  = pt_v_q && beat_take;
  assign in_ready_o = !pt_v_q || (beat_fire && last_c);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    pt_v_d   = pt_v_q;
    first_d  = first_q;
    mask_d   = mask_q;
    left_d   = left_q;
    count_d  = count_q;
    beat_v_d = beat_v_q;
    if (beat_ready_i) begin
      beat_v_d = 1'b0;
    end
    if (beat_fire) begin
      beat_v_d = 1'b1;
      if (first_q) begin
        first_d = 1'b0;
      end else begin
        mask_d = mask_q & (mask_q - NR'(1));
        left_d = left_q - 3'd1;
      end
      if (last_c) begin
        pt_v_d = 1'b0;
      end
    end
    if (in_fire) begin
      pt_v_d  = 1'b1;
      first_d = 1'b1;
      mask_d  = mask_in;
      left_d  = take;
      count_d = last_point_i ? '0 : count_q + (IB + 1)'(take);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_v_q   <= 1'b0;
      first_q  <= 1'b0;
      mask_q   <= '0;
      left_q   <= '0;
      count_q  <= '0;
      beat_v_q <= 1'b0;
    end else begin
      pt_v_q   <= pt_v_d;
      first_q  <= first_d;
      mask_q   <= mask_d;
      left_q   <= left_d;
      count_q  <= count_d;
      beat_v_q <= beat_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q    <= point_index_i;
      crd_q    <= c_in;
      ord_q    <= count_q[IB-1:0];
      ovf_q    <= ovf_in;
    end else if (beat_fire && !first_q) begin
      ord_q    <= ord_q + IB'(1);
    end
    if (beat_fire) begin
      beat_ghost_o <= !first_q;
      beat_index_o <= idx_q;
      beat_ord_o   <= first_q ? '0 : ord_q;
      beat_ovf_o   <= ovf_q;
      beat_last_o  <= last_c;
      beat_neg_o   <= neg_c;
      beat_mag_o   <= mag_c;
    end
  end

  assign beat_valid_o = beat_v_q;

endmodule

@@ src/pgg_rescale.sv @@
// Two-stage rescale of each coordinate: scale multiply, then round and clamp.
module pgg_rescale #(
  parameter int unsigned CW = 24,
  parameter int unsigned IB = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pgg_pkg::cfg_t    cfg_i,
  input  logic             beat_valid_i,
  output logic             beat_ready_o,
  input  logic             beat_ghost_i,
  input  logic [IB-1:0]    beat_index_i,
  input  logic [IB-1:0]    beat_ord_i,
  input  logic             beat_ovf_i,
  input  logic             beat_last_i,
  input  logic [2:0]       beat_neg_i,
  input  logic [2:0][CW:0] beat_mag_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             is_ghost_o,
  output logic [IB-1:0]    source_index_o,
  output logic [IB-1:0]    ghost_ordinal_o,
  output logic [CW:0]      x_out_o,
  output logic [CW:0]      y_out_o,
  output logic [CW:0]      z_out_o,
  output logic             capacity_overflow_o,
  output logic             last_of_point_o
);

  localparam int unsigned MW    = CW + 1;
  localparam int unsigned PRODW = MW + pgg_pkg::SCALE_W;
  localparam int unsigned RW    = PRODW + 1 - pgg_pkg::SCALE_FRAC;

  localparam logic [PRODW:0] ROUND_C = (PRODW + 1)'(1) << (pgg_pkg::SCALE_FRAC - 1);
  localparam logic [RW-1:0]  HALF_R  = RW'(1) << (CW - 1);
  localparam logic [RW-1:0]  ONE_R   = RW'(1) << CW;

  logic                   p_v_q, o_v_q;
  logic                   p_take, o_take;
  logic [2:0][PRODW-1:0]  prod_q;
  logic [2:0]             neg_q;
  logic                   ghost_q, ovf_q, last_q;
  logic [IB-1:0]          index_q, ord_q;
  logic [2:0][RW-1:0]     r_c;
  logic [2:0][MW-1:0]     v_c;

  assign o_take       = !o_v_q || out_ready_i;
  assign p_take       = !p_v_q || o_take;
  assign beat_ready_o = p_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (p_take) begin
        p_v_q <= beat_valid_i;
      end
      if (o_take) begin
        o_v_q <= p_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_take && beat_valid_i) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= PRODW'(beat_mag_i[a]) * PRODW'(cfg_i.scale);
      end
      neg_q   <= beat_neg_i;
      ghost_q <= beat_ghost_i;
      index_q <= beat_index_i;
      ord_q   <= beat_ord_i;
      ovf_q   <= beat_ovf_i;
      last_q  <= beat_last_i;
    end
  end

  // Round half away from zero on the magnitude, re-center, clamp to [0, one].
  always_comb begin
    logic [PRODW:0] sum;
    for (int a = 0; a < 3; a++) begin
      sum    = (PRODW + 1)'(prod_q[a]) + ROUND_C;
      r_c[a] = sum[PRODW:pgg_pkg::SCALE_FRAC];
      if (neg_q[a]) begin
        v_c[a] = (r_c[a] > HALF_R) ? '0 : MW'(HALF_R - r_c[a]);
      end else begin
        v_c[a] = (r_c[a] > HALF_R) ? MW'(ONE_R) : MW'(HALF_R + r_c[a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_take && p_v_q) begin
      is_ghost_o          <= ghost_q;
      source_index_o      <= index_q;
      ghost_ordinal_o     <= ord_q;
      x_out_o             <= v_c[0];
      y_out_o             <= v_c[1];
      z_out_o             <= cfg_i.is3 ? v_c[2] : '0;
      capacity_overflow_o <= ovf_q;
      last_of_point_o     <= last_q;
    end
  end

  assign out_valid_o = o_v_q;

endmodule

@@ src/periodic_ghost_point_generator.sv @@
// Top level: emits each point and its periodic ghost copies, rescaled.
//
//   channel | dir | handshake             | beat
//   --------+-----+-----------------------+-------------------------------------
//   in      | in  | in_valid_i/in_ready_o | one point: index, x, y, z, last flag
//   out     | out | out_valid_o/out_ready_i | original or ghost, rescaled coords
//   apb     | in  | psel/penable, pready=1 | band, scale, dimension, capacity
//
// A point yields one result per cycle unless the output stalls: one result
// for an interior point, and 1 + ghosts (up to 8) at a boundary, set by the
// single-beat emitter; results pass point, beat, product and output registers.
// Reset clears all control state and loads register defaults; no clearing pass.
// Out-side stalls back up through the beat and product stages to in_ready_o.
module periodic_ghost_point_generator #(
  parameter int unsigned COORD_FRAC_BITS = 24,
  parameter int unsigned INDEX_BITS      = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pgg_pkg::ADDR_W-1:0]  paddr,
  input  logic [pgg_pkg::DATA_W-1:0]  pwdata,
  output logic [pgg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [INDEX_BITS-1:0]       point_index_i,
  input  logic [COORD_FRAC_BITS-1:0]  x_coord_i,
  input  logic [COORD_FRAC_BITS-1:0]  y_coord_i,
  input  logic [COORD_FRAC_BITS-1:0]  z_coord_i,
  input  logic                        last_point_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_ghost_o,
  output logic [INDEX_BITS-1:0]       source_index_o,
  output logic [INDEX_BITS-1:0]       ghost_ordinal_o,
  output logic [COORD_FRAC_BITS:0]    x_out_o,
  output logic [COORD_FRAC_BITS:0]    y_out_o,
  output logic [COORD_FRAC_BITS:0]    z_out_o,
  output logic                        capacity_overflow_o,
  output logic                        last_of_point_o
);

  pgg_pkg::cfg_t                 cfg;
  logic                          beat_valid, beat_ready;
  logic                          beat_ghost, beat_ovf, beat_last;
  logic [INDEX_BITS-1:0]         beat_index, beat_ord;
  logic [2:0]                    beat_neg;
  logic [2:0][COORD_FRAC_BITS:0] beat_mag;

  pgg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pgg_sched #(
    .CW (COORD_FRAC_BITS),
    .IB (INDEX_BITS)
  ) u_sched (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_index_i (point_index_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .z_coord_i     (z_coord_i),
    .last_point_i  (last_point_i),
    .beat_valid_o  (beat_valid),
    .beat_ready_i  (beat_ready),
    .beat_ghost_o  (beat_ghost),
    .beat_index_o  (beat_index),
    .beat_ord_o    (beat_ord),
    .beat_ovf_o    (beat_ovf),
    .beat_last_o   (beat_last),
    .beat_neg_o    (beat_neg),
    .beat_mag_o    (beat_mag)
  );

  pgg_rescale #(
    .CW (COORD_FRAC_BITS),
    .IB (INDEX_BITS)
  ) u_rescale (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .beat_valid_i        (beat_valid),
    .beat_ready_o        (beat_ready),
    .beat_ghost_i        (beat_ghost),
    .beat_index_i        (beat_index),
    .beat_ord_i          (beat_ord),
    .beat_ovf_i          (beat_ovf),
    .beat_last_i         (beat_last),
    .beat_neg_i          (beat_neg),
    .beat_mag_i          (beat_mag),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .is_ghost_o          (is_ghost_o),
    .source_index_o      (source_index_o),
    .ghost_ordinal_o     (ghost_ordinal_o),
    .x_out_o             (x_out_o),
    .y_out_o             (y_out_o),
    .z_out_o             (z_out_o),
    .capacity_overflow_o (capacity_overflow_o),
    .last_of_point_o     (last_of_point_o)
  );

endmodule

@@ dv/tb_periodic_ghost_point_generator.sv @@
`timescale 1ns / 100ps
// Testbench for the ghost point generator: directed and random points, scored by a local predictor.
module tb_periodic_ghost_point_generator;

  localparam int     IDX_W      = 20;
  localparam int     CRD_W      = 24;
  localparam longint ONE        = 1 << CRD_W;
  localparam longint HALF       = ONE / 2;
  localparam int     BUFF_W     = pgg_pkg::BUFF_W;
  localparam int     SCALE_W    = pgg_pkg::SCALE_W;
  localparam int     CAP_W      = pgg_pkg::CAP_W;
  localparam int     ADDR_W     = pgg_pkg::ADDR_W;
  localparam int     DATA_W     = pgg_pkg::DATA_W;
  localparam int     SCALE_FRAC = pgg_pkg::SCALE_FRAC;

  localparam pgg_pkg::cfg_t RST_CFG = pgg_pkg::CFG_RESET;

  // Shift per region and axis (x, y, z): faces, then edges, then corners.
  localparam bit [26*3*8-1:0] SHIFTS_3D = {
    "00+", "+00", "0-0", "-00", "0+0", "00-",
    "0++", "+0+", "0-+", "-0+", "++0", "+-0", "--0", "-+0",
    "+0-", "0--", "-0-", "0+-",
    "+++", "+-+", "--+", "-++", "++-", "+--", "---", "-+-"
  };
  localparam bit [8*3*8-1:0] SHIFTS_2D = {
    "+00", "0-0", "-00", "0+0", "++0", "+-0", "--0", "-+0"
  };

  typedef struct packed {
    logic             ghost;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] ord;
    logic [CRD_W:0]   x;
    logic [CRD_W:0]   y;
    logic [CRD_W:0]   z;
    logic             ovf;
    logic             tail;
  } emit_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [IDX_W-1:0]  point_index_i = '0;
  logic [CRD_W-1:0]  x_coord_i     = '0;
  logic [CRD_W-1:0]  y_coord_i     = '0;
  logic [CRD_W-1:0]  z_coord_i     = '0;
  logic              last_point_i  = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic              is_ghost_o;
  logic [IDX_W-1:0]  source_index_o;
  logic [IDX_W-1:0]  ghost_ordinal_o;
  logic [CRD_W:0]    x_out_o;
  logic [CRD_W:0]    y_out_o;
  logic [CRD_W:0]    z_out_o;
  logic              capacity_overflow_o;
  logic              last_of_point_o;

  pgg_pkg::cfg_t    shadow_cfg;
  logic [IDX_W:0]   frame_ghosts;
  emit_t            pending_emits[$];
  int unsigned      send_idle_pct = 26;
  int unsigned      recv_idle_pct = 75;
  int               fail_count    = 0;
  int               points_sent   = 0;
  int               results_seen  = 0;
  int               ghosts_seen   = 0;
  int               overflow_seen = 0;
  int               settings_used = 0;

  periodic_ghost_point_generator dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .point_index_i       (point_index_i),
    .x_coord_i           (x_coord_i),
    .y_coord_i           (y_coord_i),
    .z_coord_i           (z_coord_i),
    .last_point_i        (last_point_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .is_ghost_o          (is_ghost_o),
    .source_index_o      (source_index_o),
    .ghost_ordinal_o     (ghost_ordinal_o),
    .x_out_o             (x_out_o),
    .y_out_o             (y_out_o),
    .z_out_o             (z_out_o),
    .capacity_overflow_o (capacity_overflow_o),
    .last_of_point_o     (last_of_point_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int region_shift(logic is3, int r, int axis);
    logic [7:0] ch;
    if (is3) ch = SHIFTS_3D[8*(3*26 - 1 - (3*r + axis)) +: 8];
    else     ch = SHIFTS_2D[8*(3*8 - 1 - (3*r + axis)) +: 8];
    if (ch == "+") return 1;
    if (ch == "-") return -1;
    return 0;
  endfunction

  function automatic bit in_band(longint c, int s, longint band);
    if (s > 0) return c > 0 && c < band;
    if (s < 0) return c > ONE - band && c < ONE;
    return c > 0 && c < ONE;
  endfunction

  // Map c to scale*(c-1/2)+1/2, round half away from zero, clamp to [0, 1].
  function automatic logic [CRD_W:0] shrink_coord(longint c);
    longint d;
    longint mag;
    longint r;
    longint v;
    d   = c - HALF;
    mag = (d < 0) ? -d : d;
    r   = (mag * longint'(shadow_cfg.scale) + (longint'(1) << (SCALE_FRAC - 1)))
          >> SCALE_FRAC;
    v   = (d < 0) ? HALF - r : HALF + r;
    if (v < 0)   v = 0;
    if (v > ONE) v = ONE;
    return v[CRD_W:0];
  endfunction

  function automatic void replicate_point(logic [IDX_W-1:0] idx, logic [CRD_W-1:0] px,
                                          logic [CRD_W-1:0] py, logic [CRD_W-1:0] pz,
                                          logic last_pt);
    longint           c[3];
    longint           band;
    longint           cap;
    int               sh[8][3];
    logic [IDX_W-1:0] ord[8];
    int               n;
    int               regions;
    int               axes;
    bit               overflow;
    bit               hit;
    emit_t            e;
    c[0]    = px;
    c[1]    = py;
    c[2]    = shadow_cfg.is3 ? longint'(pz) : 0;
    band    = shadow_cfg.buff;
    if (band > HALF) band = HALF;
    cap     = shadow_cfg.cap;
    if (cap > (longint'(1) << IDX_W)) cap = longint'(1) << IDX_W;
    regions = shadow_cfg.is3 ? 26 : 8;
    axes    = shadow_cfg.is3 ? 3 : 2;
    n        = 1;
    overflow = 1'b0;
    for (int a = 0; a < 3; a++) sh[0][a] = 0;
    ord[0] = '0;
    for (int r = 0; r < regions; r++) begin
      hit = 1'b1;
      for (int a = 0; a < axes; a++) begin
        if (!in_band(c[a], region_shift(shadow_cfg.is3, r, a), band)) hit = 1'b0;
      end
      if (hit) begin
        if (frame_ghosts < cap && n < 8) begin
          for (int a = 0; a < 3; a++) sh[n][a] = region_shift(shadow_cfg.is3, r, a);
          ord[n]       = frame_ghosts[IDX_W-1:0];
          frame_ghosts = frame_ghosts + 1'b1;
          n++;
        end else begin
          overflow = 1'b1;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      e.ghost = (k > 0);
      e.src   = idx;
      e.ord   = ord[k];
      e.x     = shrink_coord(c[0] + sh[k][0] * ONE);
      e.y     = shrink_coord(c[1] + sh[k][1] * ONE);
      e.z     = shadow_cfg.is3 ? shrink_coord(c[2] + sh[k][2] * ONE) : '0;
      e.ovf   = overflow;
      e.tail  = (k == n - 1);
      pending_emits.push_back(e);
    end
    if (last_pt) frame_ghosts = '0;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : score_emits
    emit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_emits.size() == 0) begin
        $error("result for point %0d with nothing pending", source_index_o);
        fail_count++;
      end else begin
        want = pending_emits.pop_front();
        check_field("is_ghost", want.ghost, is_ghost_o);
        check_field("source_index", want.src, source_index_o);
        check_field("ghost_ordinal", want.ord, ghost_ordinal_o);
        check_field("x_out", want.x, x_out_o);
        check_field("y_out", want.y, y_out_o);
        check_field("z_out", want.z, z_out_o);
        check_field("capacity_overflow", want.ovf, capacity_overflow_o);
        check_field("last_of_point", want.tail, last_of_point_o);
        results_seen++;
        if (want.ghost) ghosts_seen++;
        if (want.ovf) overflow_seen++;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_point(logic [IDX_W-1:0] idx, logic [CRD_W-1:0] px,
                            logic [CRD_W-1:0] py, logic [CRD_W-1:0] pz, logic last_pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    point_index_i <= idx;
    x_coord_i     <= px;
    y_coord_i     <= py;
    z_coord_i     <= pz;
    last_point_i  <= last_pt;
    do @(posedge clk_i); while (!in_ready_o);
    replicate_point(idx, px, py, pz, last_pt);
    points_sent++;
  endtask

  // Drop valid and hold until every pending result has drained.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_emits.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(pgg_pkg::reg_idx_e idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      pgg_pkg::REG_BUFF:  shadow_cfg.buff  = val[BUFF_W-1:0];
      pgg_pkg::REG_SCALE: shadow_cfg.scale = val[SCALE_W-1:0];
      pgg_pkg::REG_DIM:   shadow_cfg.is3   = val[0];
      pgg_pkg::REG_CAP:   shadow_cfg.cap   = val[CAP_W-1:0];
      default:            ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [BUFF_W-1:0] b, logic [SCALE_W-1:0] s, logic d,
                                logic [CAP_W-1:0] c);
    wait_idle();
    write_reg(pgg_pkg::REG_BUFF, b);
    write_reg(pgg_pkg::REG_SCALE, s);
    write_reg(pgg_pkg::REG_DIM, d);
    write_reg(pgg_pkg::REG_CAP, c);
    settings_used++;
  endtask

  function automatic logic [CRD_W-1:0] pick_coord();
    longint band;
    longint v;
    band = shadow_cfg.buff;
    if (band > HALF) band = HALF;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom_range(ONE - 1, 1);
      3, 4:    v = (band > 1) ? longint'($urandom_range(band - 1, 1)) : HALF;
      5, 6:    v = (band > 1) ? longint'($urandom_range(ONE - 1, ONE - band + 1)) : HALF;
      7:       v = $urandom();
      default: begin
        case ($urandom_range(7))
          0:       v = 0;
          1:       v = 1;
          2:       v = band - 1;
          3:       v = band;
          4:       v = ONE - band;
          5:       v = ONE - band + 1;
          6:       v = ONE - 1;
          default: v = HALF;
        endcase
      end
    endcase
    return v[CRD_W-1:0];
  endfunction

  task automatic pick_settings();
    longint b;
    longint s;
    longint c;
    case ($urandom_range(4))
      0:       b = 0;
      1:       b = (1 << BUFF_W) - 1;
      2:       b = $urandom_range((1 << BUFF_W) - 1, 1);
      default: b = $urandom_range(ONE / 5, 1);
    endcase
    case ($urandom_range(3))
      0:       s = HALF;
      1:       s = ONE;
      2:       s = $urandom_range(ONE, HALF);
      default: s = (ONE * ONE) / (ONE + 2 * b);
    endcase
    case ($urandom_range(3))
      0:       c = 0;
      1:       c = $urandom_range(40, 1);
      2:       c = 1 << IDX_W;
      default: c = $urandom_range(1 << IDX_W);
    endcase
    apply_settings(b[BUFF_W-1:0], s[SCALE_W-1:0], 1'($urandom_range(1)), c[CAP_W-1:0]);
  endtask

  task automatic test_reset_settings();
    longint b;
    b = RST_CFG.buff;
    send_point(20'd0, HALF[CRD_W-1:0], HALF[CRD_W-1:0], HALF[CRD_W-1:0], 1'b0);
    send_point('1, 24'd1, 24'd1, 24'd1, 1'b0);
    send_point(20'h5A5A5, '1, '1, '1, 1'b0);
    // zero coordinate sits in no band and not in the interior
    send_point(20'd3, 24'd0, 24'd1, 24'd1, 1'b0);
    send_point(20'd4, CRD_W'(b - 1), CRD_W'(ONE - b + 1), HALF[CRD_W-1:0], 1'b0);
    send_point(20'd5, CRD_W'(b), CRD_W'(ONE - b), HALF[CRD_W-1:0], 1'b0);
    send_point(20'd6, 24'd1, '1, 24'd1, 1'b1);
    send_point(20'd7, 24'd1, 24'd1, '1, 1'b0);
  endtask

  task automatic test_plane_mode();
    apply_settings(RST_CFG.buff, RST_CFG.scale, 1'b0, RST_CFG.cap);
    send_point(20'd10, 24'd1, 24'd1, CRD_W'($urandom()), 1'b0);
    send_point(20'd11, '1, 24'd1, '1, 1'b0);
    send_point(20'd12, HALF[CRD_W-1:0], '1, 24'd0, 1'b0);
    send_point(20'd13, 24'd0, HALF[CRD_W-1:0], 24'd1, 1'b0);
    send_point(20'd14, 24'd1, HALF[CRD_W-1:0], 24'd0, 1'b1);
  endtask

  task automatic test_band_and_scale_limits();
    apply_settings('0, SCALE_W'(ONE), 1'b1, RST_CFG.cap);
    send_point(20'd20, 24'd1, 24'd1, 24'd1, 1'b0);
    send_point(20'd21, '1, 24'd0, HALF[CRD_W-1:0], 1'b0);
    // widest band at full scale: shifted copies saturate at both ends
    apply_settings('1, SCALE_W'(ONE), 1'b1, CAP_W'(1 << IDX_W));
    send_point(20'd22, 24'd1, HALF[CRD_W-1:0], '1, 1'b0);
    send_point(20'd23, CRD_W'(HALF - 2), CRD_W'(HALF + 2), HALF[CRD_W-1:0], 1'b0);
    apply_settings('1, SCALE_W'(HALF), 1'b0, CAP_W'(1 << IDX_W));
    send_point(20'd24, 24'd1, '1, 24'd5, 1'b1);
  endtask

  task automatic test_capacity_limit();
    apply_settings(RST_CFG.buff, RST_CFG.scale, 1'b1, '0);
    send_point(20'd30, 24'd1, 24'd1, 24'd1, 1'b0);
    send_point(20'd31, HALF[CRD_W-1:0], HALF[CRD_W-1:0], HALF[CRD_W-1:0], 1'b1);
    apply_settings(RST_CFG.buff, RST_CFG.scale, 1'b1, CAP_W'(3));
    send_point(20'd32, 24'd1, 24'd1, 24'd1, 1'b0);
    send_point(20'd33, '1, '1, '1, 1'b1);
    send_point(20'd34, 24'd1, 24'd1, 24'd1, 1'b0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      pick_settings();
      send_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 75 : 0;
      recv_idle_pct = (phase < 2) ? 75 : (phase < 4) ? 26 : 0;
      for (int i = 0; i < 75; i++) begin
        // hold off mid-phase until the output side has emptied
        if (phase == 2 && i == 40) wait_idle();
        send_point(IDX_W'($urandom()), pick_coord(), pick_coord(), pick_coord(),
                   ($urandom_range(19) == 0));
      end
    end
  endtask

  initial begin
    #6_000_000;
    $display("[periodic_ghost_point_generator] ERROR");
    $finish;
  end

  initial begin
    shadow_cfg   = RST_CFG;
    frame_ghosts = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_settings();
    test_plane_mode();
    test_band_and_scale_limits();
    test_capacity_limit();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d points; checked %0d results, %0d of them ghosts, %0d flagged overflow",
             points_sent, results_seen, ghosts_seen, overflow_seen);
    $display("Register settings applied: %0d (2D/3D, band, scale and capacity ends)",
             settings_used);
    if (fail_count == 0) begin
      $display("[periodic_ghost_point_generator] OK");
    end else begin
      $display("[periodic_ghost_point_generator] ERROR");
    end
    $finish;
  end

endmodule
